[rtl/core/hpa_pkg.sv]
// ----------------------------------------------------------------------------
// hpa_pkg
// Shared types and codes for the hashed port allocator: operation and status
// codes, scan window limits and the table entry layout.
// ----------------------------------------------------------------------------
package hpa_pkg;

  // owner key is service id over process number
  localparam int KEY_W = 64;
  // residue register width, covers hash moduli up to 1024
  localparam int REM_W = 10;

  // operation codes on the kind field
  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_FREE   = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;
  localparam logic [1:0] KIND_REG    = 2'd3;

  // result status codes
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_HELD    = 3'd1;
  localparam logic [2:0] ST_REFUSED = 3'd2;
  localparam logic [2:0] ST_NONE    = 3'd3;
  localparam logic [2:0] ST_OUTSIDE = 3'd4;

  // free-port search window, offsets from the base port
  localparam int SCAN_LO = 1000;
  localparam int SCAN_HI = 3000;

  // one table entry
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] owner;
  } entry_t;

  // residue unit result
  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] rem;
  } mod_res_t;

endpackage

[rtl/core/hashed_port_allocator.sv]
// ----------------------------------------------------------------------------
// hashed_port_allocator
// Port ownership table over TABLE_SIZE ports above BASE_PORT, held in one
// RAM of {valid, owner key} entries, walked by a read-check-write sequencer.
//
//   channel  signals                               direction
//   in       in_valid in_stall kind svc_id         request in
//            proc_no port_in
//   out      out_valid out_stall port_out status   result out
//
// Free, update and register read the named entry, decide on it and hand the
// result over when that entry decides them; allocate first waits for the
// hash residue, worked one key byte at a time. Owner search walks the whole
// table and free-port search SCAN_LO to SCAN_HI - 1, one entry a cycle.
// After reset a clearing pass writes every table entry, in_stall
// high. A stalled result waits in the output register; the next request is taken.
// ----------------------------------------------------------------------------
module hashed_port_allocator #(
  parameter int BASE_PORT    = 20000,
  parameter int HASH_MODULUS = 997,
  parameter int TABLE_SIZE   = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] svc_id,
  input  logic [31:0] proc_no,
  input  logic [15:0] port_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] port_out,
  output logic [2:0]  status
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam logic [IDX_W-1:0] OWN_END  = IDX_W'(TABLE_SIZE - 1);
  localparam logic [IDX_W-1:0] FREE_LO  = IDX_W'(hpa_pkg::SCAN_LO);
  localparam logic [IDX_W-1:0] FREE_END = IDX_W'(hpa_pkg::SCAN_HI - 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_HASH, S_RD, S_CHK, S_SCAN, S_FIN
  } state_t;

  state_t                    state;
  logic [1:0]                op;
  logic [hpa_pkg::KEY_W-1:0] key;
  logic [IDX_W-1:0]          idx;
  logic [15:0]               res_port;
  logic [2:0]                res_status;
  logic                      scan_own;
  logic [IDX_W-1:0]          scan_ptr;
  logic [IDX_W-1:0]          scan_end;
  logic                      issue_done;
  logic                      chk_vld;
  logic [IDX_W-1:0]          chk_idx;

  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  hpa_pkg::entry_t           wr_data;
  logic                      rd_en;
  logic [IDX_W-1:0]          rd_addr;
  hpa_pkg::entry_t           rd_ent;

  logic                      accept;
  logic                      mod_start;
  hpa_pkg::mod_res_t         mod_res;
  logic [16:0]               port_off;
  logic                      outside;
  logic                      match;
  logic                      hit;

  // port number of a table index
  function automatic logic [15:0] port_of(input logic [IDX_W-1:0] i);
    logic [16:0] sum;
    sum = 17'(BASE_PORT) + 17'(i);
    return sum[15:0];
  endfunction

  // request decode
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign mod_start = accept && (kind == hpa_pkg::KIND_ALLOC);
  assign port_off  = {1'b0, port_in} - 17'(BASE_PORT);
  assign outside   = port_off[16] || (port_off >= 17'(TABLE_SIZE));

  // entry compare on the read data
  assign match    = rd_ent.vld && (rd_ent.owner == key);
  assign scan_end = scan_own ? OWN_END : FREE_END;
  assign hit      = chk_vld && (scan_own ? match : !rd_ent.vld);

  // read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx;
    case (state)
      S_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx;
      end
      S_SCAN: begin
        rd_en   = !issue_done;
        rd_addr = scan_ptr;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = idx;
      end
    endcase
  end

  hpa_mod #(
    .MODULUS (HASH_MODULUS)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .key   ({svc_id, proc_no}),
    .res   (mod_res)
  );

  hpa_ram #(
    .WIDTH ($bits(hpa_pkg::entry_t)),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_ent)
  );

  // sequencer, table write register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      scan_ptr   <= '0;
      wr_en      <= 1'b0;
      out_valid  <= 1'b0;
      chk_vld    <= 1'b0;
      issue_done <= 1'b0;
    end else begin
      wr_en <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        // clearing pass, one entry a cycle
        S_CLR: begin
          wr_en   <= 1'b1;
          wr_addr <= scan_ptr;
          wr_data <= '0;
          if (scan_ptr == OWN_END) begin
            state <= S_IDLE;
          end else begin
            scan_ptr <= scan_ptr + 1'b1;
          end
        end
        // take a request
        S_IDLE: begin
          if (accept) begin
            op  <= kind;
            key <= {svc_id, proc_no};
            idx <= port_off[IDX_W-1:0];
            if (kind == hpa_pkg::KIND_ALLOC) begin
              state <= S_HASH;
            end else if (outside) begin
              res_port   <= '0;
              res_status <= hpa_pkg::ST_OUTSIDE;
              state      <= S_FIN;
            end else begin
              state <= S_RD;
            end
          end
        end
        // wait for the home index
        S_HASH: begin
          if (mod_res.done) begin
            idx   <= IDX_W'(mod_res.rem);
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        // decide on the named or home entry
        S_CHK: begin
          state <= S_FIN;
          case (op)
            hpa_pkg::KIND_ALLOC: begin
              if (!rd_ent.vld) begin
                wr_en      <= 1'b1;
                wr_addr    <= idx;
                wr_data    <= {1'b1, key};
                res_port   <= port_of(idx);
                res_status <= hpa_pkg::ST_DONE;
              end else if (match) begin
                res_port   <= port_of(idx);
                res_status <= hpa_pkg::ST_HELD;
              end else begin
                scan_own   <= 1'b1;
                scan_ptr   <= '0;
                issue_done <= 1'b0;
                chk_vld    <= 1'b0;
                state      <= S_SCAN;
              end
            end
            hpa_pkg::KIND_FREE: begin
              if (match) begin
                wr_en      <= 1'b1;
                wr_addr    <= idx;
                wr_data    <= {1'b0, key};
                res_port   <= port_of(idx);
                res_status <= hpa_pkg::ST_DONE;
              end else begin
                scan_own   <= 1'b1;
                scan_ptr   <= '0;
                issue_done <= 1'b0;
                chk_vld    <= 1'b0;
                state      <= S_SCAN;
              end
            end
            hpa_pkg::KIND_UPDATE: begin
              wr_en      <= 1'b1;
              wr_addr    <= idx;
              wr_data    <= {1'b1, key};
              res_port   <= port_of(idx);
              res_status <= match ? hpa_pkg::ST_HELD : hpa_pkg::ST_DONE;
            end
            default: begin
              if (rd_ent.vld) begin
                res_port   <= '0;
                res_status <= hpa_pkg::ST_REFUSED;
              end else begin
                wr_en      <= 1'b1;
                wr_addr    <= idx;
                wr_data    <= {1'b1, key};
                res_port   <= port_of(idx);
                res_status <= hpa_pkg::ST_DONE;
              end
            end
          endcase
        end
        // table walk, one read issued and one entry checked a cycle
        S_SCAN: begin
          chk_vld <= !issue_done;
          if (!issue_done) begin
            chk_idx <= scan_ptr;
            if (scan_ptr == scan_end) begin
              issue_done <= 1'b1;
            end else begin
              scan_ptr <= scan_ptr + 1'b1;
            end
          end
          if (hit) begin
            state    <= S_FIN;
            res_port <= port_of(chk_idx);
            if (!scan_own) begin
              wr_en      <= 1'b1;
              wr_addr    <= chk_idx;
              wr_data    <= {1'b1, key};
              res_status <= hpa_pkg::ST_DONE;
            end else if (op == hpa_pkg::KIND_FREE) begin
              wr_en      <= 1'b1;
              wr_addr    <= chk_idx;
              wr_data    <= {1'b0, key};
              res_status <= hpa_pkg::ST_DONE;
            end else begin
              res_status <= hpa_pkg::ST_HELD;
            end
          end else if (chk_vld && (chk_idx == scan_end)) begin
            if (scan_own && (op == hpa_pkg::KIND_ALLOC)) begin
              // owner holds nothing, look for a free port
              scan_own   <= 1'b0;
              scan_ptr   <= FREE_LO;
              issue_done <= 1'b0;
              chk_vld    <= 1'b0;
            end else begin
              state      <= S_FIN;
              res_port   <= '0;
              res_status <= scan_own ? hpa_pkg::ST_NONE : hpa_pkg::ST_REFUSED;
            end
          end
        end
        // hand the result to the output register
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            port_out  <= res_port;
            status    <= res_status;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a new result only comes from the hand-over state
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result raised outside hand-over");

  // failed requests report port zero
  a_fail_port_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == hpa_pkg::ST_REFUSED || status == hpa_pkg::ST_NONE ||
                  status == hpa_pkg::ST_OUTSIDE) |-> port_out == 16'd0)
    else $error("failed request with nonzero port");

  // table write never meets a read of the same entry
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    wr_en && rd_en |-> wr_addr != rd_addr)
    else $error("table read and write to the same entry");

  // no request is taken during the clearing pass
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    $past(state == S_CLR) && state == S_CLR |-> !accept)
    else $error("request taken while clearing");

endmodule

[rtl/core/hpa_ram.sv]
// ----------------------------------------------------------------------------
// hpa_ram
// Generic simple dual-port RAM: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module hpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/hpa_mod.sv]
// ----------------------------------------------------------------------------
// hpa_mod
// Residue of the 64-bit owner key modulo a constant, one key byte at a time in a
// multiply phase and a reduce phase: a reciprocal multiply estimates the
// quotient, then one compare and subtract corrects it.
// ----------------------------------------------------------------------------
module hpa_mod #(
  parameter int MODULUS = 997
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hpa_pkg::KEY_W-1:0]   key,
  output hpa_pkg::mod_res_t           res
);

  localparam int DIG_W = 8;
  localparam int N_DIG = hpa_pkg::KEY_W / DIG_W;
  localparam int CNT_W = $clog2(N_DIG + 1);
  // running residue over the next key byte
  localparam int X_W   = hpa_pkg::REM_W + DIG_W;
  // reciprocal scale keeps the quotient estimate at most one low
  localparam int SHIFT = X_W + hpa_pkg::REM_W;
  localparam int RCP_W = SHIFT + 1;
  localparam int P_W   = X_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << SHIFT) / MODULUS);
  localparam logic [X_W-1:0]   MOD_X = X_W'(MODULUS);

  logic [hpa_pkg::KEY_W-1:0] sh;
  logic [hpa_pkg::REM_W-1:0] rem;
  logic [hpa_pkg::REM_W-1:0] rem_next;
  logic [X_W-1:0]            part;
  logic [X_W-1:0]            part_next;
  logic [P_W-1:0]            prod;
  logic [X_W-1:0]            quot;
  logic [X_W-1:0]            diff;
  logic [CNT_W-1:0]          cnt;
  logic                      phase;
  logic                      busy;
  logic                      done;

  // next partial value, quotient estimate and corrected residue
  always_comb begin
    part_next = {rem, sh[hpa_pkg::KEY_W-1 -: DIG_W]};
    quot      = prod[SHIFT +: X_W];
    diff      = part - quot * MOD_X;
    if (diff >= MOD_X) begin
      rem_next = hpa_pkg::REM_W'(diff - MOD_X);
    end else begin
      rem_next = hpa_pkg::REM_W'(diff);
    end
  end

  // iteration control, multiply phase then reduce phase for each byte
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        sh    <= key;
        rem   <= '0;
        cnt   <= CNT_W'(N_DIG);
        phase <= 1'b0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (!phase) begin
          part  <= part_next;
          prod  <= P_W'(part_next) * P_W'(RECIP);
          sh    <= sh << DIG_W;
          phase <= 1'b1;
        end else begin
          rem   <= rem_next;
          cnt   <= cnt - 1'b1;
          phase <= 1'b0;
          if (cnt == CNT_W'(1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign res.done = done;
  assign res.rem  = rem;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hashed_port_allocator. A directed table covers
// reset state, window edges and each fallback path. A random phase follows,
// drawing owners mostly from a small colliding pool and ports partly from
// those already handed out. Every result is checked against an in-bench
// copy of the ownership table or, for typed rows, a hand-written value. Both
// sides idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

  localparam int BASE        = 20000;
  localparam int HASH_M      = 997;
  localparam int TABLE_N     = 4096;
  localparam int N_RANDOM    = 116;
  localparam int HOLD_OFF    = 300;
  localparam int IDLE_LIMIT  = 40000;
  localparam int SETTLE      = 32;

  typedef struct packed {
    logic [15:0] port;
    logic [2:0]  st;
  } grant_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sid;
    logic [31:0] pno;
    logic [15:0] prt;
    logic        typed;
    logic [15:0] exp_port;
    logic [2:0]  exp_st;
  } row_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [1:0]  kind       = hpa_pkg::KIND_ALLOC;
  logic [31:0] svc_id     = '0;
  logic [31:0] proc_no    = '0;
  logic [15:0] port_in    = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [15:0] port_out;
  logic [2:0]  status;

  // shadow copy of the ownership table
  logic        own_vld [TABLE_N];
  logic [63:0] own_key [TABLE_N];

  grant_t      grants_due [$];
  logic [15:0] seen_ports [$];
  row_t        plan [$];

  int errors       = 0;
  int results_seen = 0;
  int idle_cycles  = 0;
  int n_kind [4];
  int n_st [5];
  bit held_off     = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hashed_port_allocator #(
    .BASE_PORT   (BASE),
    .HASH_MODULUS(HASH_M),
    .TABLE_SIZE  (TABLE_N)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .svc_id    (svc_id),
    .proc_no   (proc_no),
    .port_in   (port_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .port_out  (port_out),
    .status    (status)
  );

  // lowest entry held by key, TABLE_N when none
  function automatic int lowest_held(input logic [63:0] key);
    int i;
    for (i = 0; i < TABLE_N; i++)
      if (own_vld[i] && own_key[i] == key) return i;
    return TABLE_N;
  endfunction

  // apply one request to the shadow table and work out its result
  function automatic void claim_port(input logic [1:0] k, input logic [63:0] key,
                                     input logic [15:0] prt,
                                     output logic [15:0] po, output logic [2:0] st);
    int home;
    int j;
    int off;
    po = '0;
    st = hpa_pkg::ST_REFUSED;
    if (k == hpa_pkg::KIND_ALLOC) begin
      home = int'(key % 64'(HASH_M));
      if (!own_vld[home]) begin
        own_vld[home] = 1'b1;
        own_key[home] = key;
        po = 16'(BASE + home);
        st = hpa_pkg::ST_DONE;
        return;
      end
      if (own_key[home] == key) begin
        po = 16'(BASE + home);
        st = hpa_pkg::ST_HELD;
        return;
      end
      j = lowest_held(key);
      if (j < TABLE_N) begin
        po = 16'(BASE + j);
        st = hpa_pkg::ST_HELD;
        return;
      end
      for (j = hpa_pkg::SCAN_LO; j < hpa_pkg::SCAN_HI && j < TABLE_N; j++) begin
        if (!own_vld[j]) begin
          own_vld[j] = 1'b1;
          own_key[j] = key;
          po = 16'(BASE + j);
          st = hpa_pkg::ST_DONE;
          return;
        end
      end
      return;
    end
    off = int'(prt) - BASE;
    if (off < 0 || off >= TABLE_N) begin
      st = hpa_pkg::ST_OUTSIDE;
      return;
    end
    case (k)
      hpa_pkg::KIND_FREE: begin
        if (own_vld[off] && own_key[off] == key) begin
          own_vld[off] = 1'b0;
          po = prt;
          st = hpa_pkg::ST_DONE;
        end else begin
          j = lowest_held(key);
          if (j < TABLE_N) begin
            own_vld[j] = 1'b0;
            po = 16'(BASE + j);
            st = hpa_pkg::ST_DONE;
          end else begin
            st = hpa_pkg::ST_NONE;
          end
        end
      end
      hpa_pkg::KIND_UPDATE: begin
        st = (own_vld[off] && own_key[off] == key) ? hpa_pkg::ST_HELD : hpa_pkg::ST_DONE;
        own_vld[off] = 1'b1;
        own_key[off] = key;
        po = prt;
      end
      hpa_pkg::KIND_REG: begin
        if (!own_vld[off]) begin
          own_vld[off] = 1'b1;
          own_key[off] = key;
          po = prt;
          st = hpa_pkg::ST_DONE;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // offer one request after a random gap, then log what it should return
  task automatic send_request(input logic [1:0] k, input logic [31:0] sid,
                              input logic [31:0] pno, input logic [15:0] prt,
                              input logic typed, input logic [15:0] t_port,
                              input logic [2:0] t_st);
    int gap;
    grant_t g;
    logic [15:0] po;
    logic [2:0] st;
    gap = $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    svc_id     <= sid;
    proc_no    <= pno;
    port_in    <= prt;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    claim_port(k, {sid, pno}, prt, po, st);
    // typed rows are checked against the hand-written value
    if (typed) begin
      po = t_port;
      st = t_st;
    end
    g.port = po;
    g.st   = st;
    grants_due = {grants_due, g};
    n_kind[k]++;
    if (st <= hpa_pkg::ST_OUTSIDE) n_st[st]++;
    if (po != '0) begin
      seen_ports = {seen_ports, po};
      if (seen_ports.size() > 64) void'(seen_ports.pop_front());
    end
  endtask

  task automatic add_row(input logic [1:0] k, input logic [31:0] sid, input logic [31:0] pno,
                         input logic [15:0] prt, input logic typed,
                         input logic [15:0] ep, input logic [2:0] es);
    row_t r;
    r.kind = k;
    r.sid = sid;
    r.pno = pno;
    r.prt = prt;
    r.typed = typed;
    r.exp_port = ep;
    r.exp_st = es;
    plan = {plan, r};
  endtask

  // result side: random stalls, one long hold-off, field-by-field check
  initial begin : drain
    int n;
    grant_t want;
    logic [15:0] got_port;
    logic [2:0] got_st;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (!held_off && results_seen >= 40) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
      end
      n = $urandom_range(0, 8);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      got_port = port_out;
      got_st   = status;
      @(posedge clk);
      results_seen++;
      if (grants_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got port %0d status %0d",
                 $time, got_port, got_st);
      end else begin
        want = grants_due.pop_front();
        if (got_port !== want.port) begin
          errors++;
          $display("%0t: port_out mismatch, expected %0d, got %0d",
                   $time, want.port, got_port);
        end
        if (got_st !== want.st) begin
          errors++;
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.st, got_st);
        end
      end
    end
  end

  // watchdog on cycles where neither channel moves
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog, %0d cycles with no request or result moving, %0d pending",
               $time, idle_cycles, grants_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int r;
    logic [1:0] k;
    logic [63:0] key;
    logic [15:0] prt;
    logic [63:0] key_pool [8];
    row_t row;

    for (i = 0; i < TABLE_N; i++) begin
      own_vld[i] = 1'b0;
      own_key[i] = '0;
    end
    for (i = 0; i < 4; i++) n_kind[i] = 0;
    for (i = 0; i < 5; i++) n_st[i] = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table
    add_row(hpa_pkg::KIND_ALLOC,  32'd0, 32'd5,    16'd0,     1, 16'd20005,
            hpa_pkg::ST_DONE);
    add_row(hpa_pkg::KIND_ALLOC,  32'd0, 32'd5,    16'hFFFF,  1, 16'd20005,
            hpa_pkg::ST_HELD);
    add_row(hpa_pkg::KIND_ALLOC,  32'd0, 32'd1002, 16'd0,     1, 16'd21000,
            hpa_pkg::ST_DONE);
    add_row(hpa_pkg::KIND_ALLOC,  32'd0, 32'd1002, 16'd0,     1, 16'd21000,
            hpa_pkg::ST_HELD);
    add_row(hpa_pkg::KIND_REG,    32'd1, 32'd1,    16'd20005, 1, 16'd0,
            hpa_pkg::ST_REFUSED);
    add_row(hpa_pkg::KIND_REG,    32'd1, 32'd1,    16'd20010, 1, 16'd20010,
            hpa_pkg::ST_DONE);
    add_row(hpa_pkg::KIND_FREE,   32'd1, 32'd1,    16'd20005, 1, 16'd20010,
            hpa_pkg::ST_DONE);
    add_row(hpa_pkg::KIND_FREE,   32'd1, 32'd1,    16'd20005, 1, 16'd0,
            hpa_pkg::ST_NONE);
    add_row(hpa_pkg::KIND_FREE,   32'd0, 32'd5,    16'd19999, 1, 16'd0,
            hpa_pkg::ST_OUTSIDE);
    add_row(hpa_pkg::KIND_UPDATE, 32'd0, 32'd5,    16'd24096, 1, 16'd0,
            hpa_pkg::ST_OUTSIDE);
    add_row(hpa_pkg::KIND_REG,    32'd0, 32'd5,    16'hFFFF,  1, 16'd0,
            hpa_pkg::ST_OUTSIDE);
    add_row(hpa_pkg::KIND_REG,    32'd0, 32'd5,    16'd0,     1, 16'd0,
            hpa_pkg::ST_OUTSIDE);
    add_row(hpa_pkg::KIND_UPDATE, '1,    '1,       16'd24095, 1, 16'd24095,
            hpa_pkg::ST_DONE);
    add_row(hpa_pkg::KIND_UPDATE, '1,    '1,       16'd24095, 1, 16'd24095,
            hpa_pkg::ST_HELD);
    add_row(hpa_pkg::KIND_UPDATE, 32'd1, 32'd1,    16'd24095, 1, 16'd24095,
            hpa_pkg::ST_DONE);
    add_row(hpa_pkg::KIND_REG,    '1,    32'd0,    16'd20000, 1, 16'd20000,
            hpa_pkg::ST_DONE);
    add_row(hpa_pkg::KIND_FREE,   '1,    32'd0,    16'd20000, 1, 16'd20000,
            hpa_pkg::ST_DONE);
    add_row(hpa_pkg::KIND_ALLOC,  32'd0, 32'd0,    16'd0,     1, 16'd20000,
            hpa_pkg::ST_DONE);
    add_row(hpa_pkg::KIND_ALLOC,  '1,    '1,       16'd0,     0, 16'd0,
            hpa_pkg::ST_DONE);
    add_row(hpa_pkg::KIND_UPDATE, 32'd0, 32'd5,    16'd23000, 0, 16'd0,
            hpa_pkg::ST_DONE);
    add_row(hpa_pkg::KIND_FREE,   32'd0, 32'd5,    16'd23000, 0, 16'd0,
            hpa_pkg::ST_DONE);
    add_row(hpa_pkg::KIND_FREE,   32'd0, 32'd5,    16'd24096, 1, 16'd0,
            hpa_pkg::ST_OUTSIDE);
    add_row(hpa_pkg::KIND_FREE,   32'd0, 32'd1002, 16'd20005, 0, 16'd0,
            hpa_pkg::ST_DONE);
    add_row(hpa_pkg::KIND_ALLOC,  32'd0, 32'd1002, 16'd0,     0, 16'd0,
            hpa_pkg::ST_DONE);
    for (i = 0; i < plan.size(); i++) begin
      row = plan[i];
      send_request(row.kind, row.sid, row.pno, row.prt, row.typed, row.exp_port, row.exp_st);
    end

    // owner pool, second half shares home ports with the first
    for (i = 0; i < 4; i++) begin
      key_pool[i]     = {$urandom, $urandom};
      key_pool[i + 4] = key_pool[i] + 64'(HASH_M);
    end

    // random requests, mostly against pool owners, often against ports already in play
    for (i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      k = (r < 35) ? hpa_pkg::KIND_ALLOC :
          (r < 60) ? hpa_pkg::KIND_FREE :
          (r < 75) ? hpa_pkg::KIND_UPDATE : hpa_pkg::KIND_REG;
      if ($urandom_range(0, 99) < 85)
        key = key_pool[$urandom_range(0, 7)];
      else
        key = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 45 && seen_ports.size() > 0) begin
        prt = seen_ports[$urandom_range(0, seen_ports.size() - 1)];
      end else if (r < 75) begin
        prt = 16'(BASE + $urandom_range(0, TABLE_N - 1));
      end else if (r < 85) begin
        case ($urandom_range(0, 3))
          0: prt = 16'(BASE);
          1: prt = 16'(BASE + TABLE_N - 1);
          2: prt = 16'(BASE - 1);
          default: prt = 16'(BASE + TABLE_N);
        endcase
      end else begin
        prt = 16'($urandom);
      end
      send_request(k, key[63:32], key[31:0], prt, 0, '0, hpa_pkg::ST_DONE);
    end
    in_valid <= 1'b0;

    while (grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("summary: %0d requests (allocate %0d, free %0d, update %0d, register %0d), %0d results",
             n_kind[hpa_pkg::KIND_ALLOC] + n_kind[hpa_pkg::KIND_FREE] +
             n_kind[hpa_pkg::KIND_UPDATE] + n_kind[hpa_pkg::KIND_REG],
             n_kind[hpa_pkg::KIND_ALLOC], n_kind[hpa_pkg::KIND_FREE],
             n_kind[hpa_pkg::KIND_UPDATE], n_kind[hpa_pkg::KIND_REG],
             results_seen);
    $display("summary: done %0d, held %0d, refused %0d, nothing freed %0d, outside %0d, %0d errors",
             n_st[hpa_pkg::ST_DONE], n_st[hpa_pkg::ST_HELD], n_st[hpa_pkg::ST_REFUSED],
             n_st[hpa_pkg::ST_NONE], n_st[hpa_pkg::ST_OUTSIDE], errors);
    if (errors == 0 && grants_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
